>>> rtl/rrqs_pkg.sv
// Types and constants shared by the round-robin quantum scheduler modules.
package rrqs_pkg;

	localparam logic [7:0] QUANTUM_RESET = 8'd12;

	localparam logic [2:0] STAT_NONE     = 3'd0;
	localparam logic [2:0] STAT_ACCEPTED = 3'd1;
	localparam logic [2:0] STAT_DROPPED  = 3'd2;
	localparam logic [2:0] STAT_DONE     = 3'd3;
	localparam logic [2:0] STAT_PREEMPT  = 3'd4;

	localparam logic REQ_ARRIVAL = 1'b0;
	localparam logic REQ_TICK    = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_FETCH = 2'b10
	} state_t;

	typedef struct packed {
		logic [15:0] id;
		logic [15:0] rem;
		logic [15:0] svc;
		logic [31:0] arrival;
	} entry_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] id;
		logic [31:0] stamp;
		logic [31:0] waiting;
		logic [31:0] completion;
		logic [8:0]  qcount;
	} result_t;

endpackage

>>> rtl/round_robin_quantum_scheduler.sv
// Top level of the round-robin job scheduler with a programmable time quantum.
//
//   Channel  Direction  Contents
//   s_*      in         requests: job arrival or clock tick
//   m_*      out        one result per request
//   cfg_*    in         time quantum register write
//
// A tick that finds the processor idle and a job waiting first reads the head entry
// from the queue RAM in the fetch state; every other request is handled in the idle state.
// There is no clearing pass after reset; the queue RAM is read only where written.
// A request is taken while a result waits if that result leaves in the same cycle.
module round_robin_quantum_scheduler #(
	parameter int QUEUE_DEPTH = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [31:0]  s_tdata,   // job_id [15:0], service_time [31:16]
	input  logic [0:0]   s_tuser,   // req_type [0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // done_job_id, arrival_stamp, waiting_ticks,
	                                // completion_tick, queue_count, zero fill
	output logic [2:0]   m_tuser,   // status [2:0]
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [7:0]   cfg_data
);

	import rrqs_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
	localparam logic [AW-1:0] LAST_C  = AW'(QUEUE_DEPTH - 1);

	function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
		return (p == LAST_C) ? '0 : p + AW'(1);
	endfunction

	state_t        state_q, state_d;
	logic [31:0]   clock_q, clock_d;
	logic [AW-1:0] head_q, head_d, tail_q, tail_d;
	logic [CW-1:0] count_q, count_d;
	logic          busy_q, busy_d;
	logic [15:0]   cpu_id_q, cpu_id_d, cpu_rem_q, cpu_rem_d, cpu_svc_q, cpu_svc_d;
	logic [31:0]   cpu_arr_q, cpu_arr_d;
	logic [7:0]    ql_q, ql_d;
	logic [7:0]    tq_q;

	logic          in_acc, is_tick, dispatch_go, do_exec, out_free;
	logic          wr_en;
	entry_t        wr_data, rd_data;
	logic [$bits(entry_t)-1:0] rd_raw;
	result_t       res, out_res;
	logic          res_load;

	logic          ex_busy, dec;
	logic [15:0]   ex_id, ex_rem, ex_svc, rem2;
	logic [31:0]   ex_arr, clk1;
	logic [7:0]    ex_ql, ql2, load_q;
	logic [CW-1:0] ex_count;
	logic [AW-1:0] ex_head;
	logic [CW+8:0] qc_ext;

	assign cfg_ready   = 1'b1;
	assign in_acc      = s_tvalid && s_tready;
	assign is_tick     = (s_tuser[0] == REQ_TICK);
	assign s_tready    = (state_q == ST_IDLE) && out_free;
	assign dispatch_go = in_acc && is_tick && !busy_q && (count_q != '0);
	assign load_q      = (tq_q == 8'd0) ? 8'd1 : tq_q;
	assign rd_data     = entry_t'(rd_raw);

	rrqs_ram #(.W($bits(entry_t)), .D(QUEUE_DEPTH)) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (tail_q),
		.wr_data (wr_data),
		.rd_en   (dispatch_go),
		.rd_addr (head_q),
		.rd_data (rd_raw)
	);

	always_comb begin
		if (state_q == ST_FETCH) begin
			ex_busy  = 1'b1;
			ex_id    = rd_data.id;
			ex_rem   = rd_data.rem;
			ex_svc   = rd_data.svc;
			ex_arr   = rd_data.arrival;
			ex_ql    = load_q;
			ex_count = count_q - CW'(1);
			ex_head  = next_ptr(head_q);
		end else begin
			ex_busy  = busy_q;
			ex_id    = cpu_id_q;
			ex_rem   = cpu_rem_q;
			ex_svc   = cpu_svc_q;
			ex_arr   = cpu_arr_q;
			ex_ql    = ql_q;
			ex_count = count_q;
			ex_head  = head_q;
		end
		dec  = ex_busy && (ex_rem != 16'd0) && (ex_ql != 8'd0);
		rem2 = dec ? ex_rem - 16'd1 : ex_rem;
		ql2  = dec ? ex_ql - 8'd1 : ex_ql;
		clk1 = clock_q + 32'd1;
	end

	always_comb begin
		state_d   = state_q;
		clock_d   = clock_q;
		head_d    = head_q;
		tail_d    = tail_q;
		count_d   = count_q;
		busy_d    = busy_q;
		cpu_id_d  = cpu_id_q;
		cpu_rem_d = cpu_rem_q;
		cpu_svc_d = cpu_svc_q;
		cpu_arr_d = cpu_arr_q;
		ql_d      = ql_q;
		res       = '0;
		res_load  = 1'b0;
		do_exec   = 1'b0;
		wr_en     = 1'b0;
		wr_data   = '{id: s_tdata[15:0], rem: s_tdata[31:16], svc: s_tdata[31:16],
		              arrival: clock_q};

		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (!is_tick) begin
						res_load  = 1'b1;
						res.stamp = clock_q;
						if (count_q != DEPTH_C) begin
							wr_en      = 1'b1;
							tail_d     = next_ptr(tail_q);
							count_d    = count_q + CW'(1);
							res.status = STAT_ACCEPTED;
						end else begin
							res.status = STAT_DROPPED;
						end
					end else if (dispatch_go) begin
						state_d = ST_FETCH;
					end else begin
						do_exec = 1'b1;
					end
				end
			end
			ST_FETCH: begin
				do_exec = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (do_exec) begin
			res_load  = 1'b1;
			clock_d   = clk1;
			count_d   = ex_count;
			head_d    = ex_head;
			busy_d    = ex_busy;
			cpu_id_d  = ex_id;
			cpu_rem_d = rem2;
			cpu_svc_d = ex_svc;
			cpu_arr_d = ex_arr;
			ql_d      = ql2;
			if (ex_busy) begin
				if (rem2 == 16'd0) begin
					res.status     = STAT_DONE;
					res.id         = ex_id;
					res.stamp      = ex_arr;
					res.completion = clk1;
					res.waiting    = clk1 - ex_arr - {16'd0, ex_svc};
					busy_d         = 1'b0;
				end else if (ql2 == 8'd0) begin
					if (ex_count != DEPTH_C) begin
						wr_en      = 1'b1;
						wr_data    = '{id: ex_id, rem: rem2, svc: ex_svc, arrival: ex_arr};
						tail_d     = next_ptr(tail_q);
						count_d    = ex_count + CW'(1);
						res.status = STAT_PREEMPT;
						res.id     = ex_id;
						res.stamp  = ex_arr;
						busy_d     = 1'b0;
					end else begin
						ql_d = load_q;
					end
				end
			end
		end

		qc_ext     = {9'd0, count_d};
		res.qcount = qc_ext[8:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			clock_q   <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			busy_q    <= 1'b0;
			cpu_id_q  <= '0;
			cpu_rem_q <= '0;
			cpu_svc_q <= '0;
			cpu_arr_q <= '0;
			ql_q      <= '0;
			tq_q      <= QUANTUM_RESET;
		end else begin
			state_q   <= state_d;
			clock_q   <= clock_d;
			head_q    <= head_d;
			tail_q    <= tail_d;
			count_q   <= count_d;
			busy_q    <= busy_d;
			cpu_id_q  <= cpu_id_d;
			cpu_rem_q <= cpu_rem_d;
			cpu_svc_q <= cpu_svc_d;
			cpu_arr_q <= cpu_arr_d;
			ql_q      <= ql_d;
			if (cfg_valid && cfg_ready) begin
				tq_q <= cfg_data;
			end
		end
	end

	rrqs_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (res_load),
		.d      (res),
		.take   (m_tready),
		.valid  (m_tvalid),
		.q      (out_res),
		.free   (out_free)
	);

	assign m_tuser = out_res.status;
	assign m_tdata = {7'd0, out_res.qcount, out_res.completion, out_res.waiting,
	                  out_res.stamp, out_res.id};

endmodule

>>> rtl/rrqs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rrqs_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [$clog2(D)-1:0] wr_addr,
	input  logic [W-1:0]         wr_data,
	input  logic                 rd_en,
	input  logic [$clog2(D)-1:0] rd_addr,
	output logic [W-1:0]         rd_data
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/rrqs_out_reg.sv
// Result holding register between the scheduler core and the output stream.
module rrqs_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  rrqs_pkg::result_t d,
	input  logic              take,
	output logic              valid,
	output rrqs_pkg::result_t q,
	output logic              free
);

	import rrqs_pkg::*;

	logic    valid_q;
	result_t data_q;

	assign free  = !valid_q || take;
	assign valid = valid_q;
	assign q     = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= d;
		end
	end

endmodule

>>> rtl/rrqs_checker.sv
// Port-level checks for the round-robin quantum scheduler, bound to the top level.
module rrqs_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [31:0]  s_tdata,
	input logic [0:0]   s_tuser,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [127:0] m_tdata,
	input logic [2:0]   m_tuser,
	input logic         cfg_valid,
	input logic         cfg_ready,
	input logic [7:0]   cfg_data
);

	import rrqs_pkg::*;

	logic unused_ok;
	assign unused_ok = ^{s_tvalid, s_tdata, cfg_valid, cfg_ready, cfg_data};

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("Result changed while stalled.");

	a_no_request_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("Request taken while the result register was blocked.");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser <= STAT_PREEMPT)
		else $error("Status code out of range.");

	a_times_only_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != STAT_DONE |-> m_tdata[111:48] == 64'd0)
		else $error("Waiting or completion time on a result that is not a completion.");

	a_preempt_queued: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == STAT_PREEMPT |-> m_tdata[120:112] != 9'd0 || s_tuser[0])
		else $error("Preempted job not counted in the queue.");

endmodule

bind round_robin_quantum_scheduler rrqs_checker u_rrqs_checker (.*);
